// ===== sv/rational_curve_shaper_macros.svh =====
// assertion helpers shared by the checker
`ifndef RATIONAL_CURVE_SHAPER_MACROS_SVH
`define RATIONAL_CURVE_SHAPER_MACROS_SVH

// same-cycle implication, quiet during reset
`define RCS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rcs assertion failed");

// next-cycle implication, also checked during reset
`define RCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("rcs assertion failed");

`endif

// ===== sv/rcs_pkg.sv =====
// ----------------------------------------------------------------------------
// rcs_pkg
// Widths, constants, register map and the sideband record of the shaper.
// ----------------------------------------------------------------------------
package rcs_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = FRAC_BITS + 1;
    localparam int NUM_W      = 2 * FRAC_BITS + 1;
    localparam int REM_W      = NUM_W + 1;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int ADDR_W     = 4;

    localparam logic [DATA_W-1:0] ONE        = DATA_W'(1) << FRAC_BITS;
    localparam logic [DATA_W-1:0] CLAMP_LOW  = DATA_W'(1);
    localparam logic [DATA_W-1:0] CLAMP_HIGH = DATA_W'(65535);

    localparam logic [2:0] MODE_UP         = 3'd0;
    localparam logic [2:0] MODE_DOWN       = 3'd1;
    localparam logic [2:0] MODE_UP_BLEND   = 3'd2;
    localparam logic [2:0] MODE_DOWN_BLEND = 3'd3;
    localparam logic [2:0] MODE_LEAN_IN    = 3'd4;
    localparam logic [2:0] MODE_LEAN_OUT   = 3'd5;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_EFFECT = 2'd1;
    localparam logic [1:0] REG_CENTER = 2'd2;

    localparam logic [DATA_W-1:0] CENTER_RESET = DATA_W'(32768);

    typedef struct packed {
        logic              pass;
        logic [DATA_W-1:0] raw;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] m;
        logic [DATA_W-1:0] c;
        logic [2:0]        mode;
        logic              gt;
        logic              lt;
        logic [DATA_W-1:0] xb;
    } t_side;

    function automatic logic [DATA_W-1:0] sat(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        r = v;
        if (v < CLAMP_LOW) r = CLAMP_LOW;
        else if (v > CLAMP_HIGH) r = CLAMP_HIGH;
        return r;
    endfunction

endpackage

// ===== sv/rational_curve_shaper.sv =====
// ----------------------------------------------------------------------------
// rational_curve_shaper
// Pipelined rational curve shaper for Q1.16 samples with APB configuration.
// ----------------------------------------------------------------------------
// Input beats arrive on i_valid / o_ready with i_sample_in; results leave on
// o_valid / i_ready with o_sample_out, one result per input beat, in order.
// Configuration (curve_mode at 0x0, effect at 0x4, center_point at 0x8) is
// written over the APB port while no beat is in flight; the user must keep
// to this, the block does not enforce it. pready is always high. The pipe has
// one input stage, a 17-stage divider for the side rescale, a multiply stage,
// a second 17-stage divider for the curve itself, a multiply stage and the
// output register. Unless stalled, throughput is one beat per cycle; each
// divider resolves one quotient bit per stage and takes a new operand each cycle.
// Reset clears all valid bits and loads the register reset values
// (mode up, effect zero, center one half).
// When the receiver holds i_ready low with a result waiting, the whole pipe
// freezes and o_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module rational_curve_shaper (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [rcs_pkg::DATA_W-1:0]          i_sample_in,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [rcs_pkg::DATA_W-1:0]          o_sample_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rcs_pkg::ADDR_W-1:0]          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int DW = rcs_pkg::DATA_W;
    localparam int FB = rcs_pkg::FRAC_BITS;

    // configuration registers
    logic [2:0]    r_mode;
    logic [DW-1:0] r_effect;
    logic [DW-1:0] r_center;
    logic [1:0]    reg_idx;
    logic          wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= rcs_pkg::MODE_UP;
            r_effect <= '0;
            r_center <= rcs_pkg::CENTER_RESET;
        end else if (wr) begin
            unique case (reg_idx)
                rcs_pkg::REG_MODE:   r_mode   <= pwdata[2:0];
                rcs_pkg::REG_EFFECT: r_effect <= pwdata[DW-1:0];
                rcs_pkg::REG_CENTER: r_center <= pwdata[DW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            rcs_pkg::REG_MODE:   prdata = {29'd0, r_mode};
            rcs_pkg::REG_EFFECT: prdata = 32'(r_effect);
            rcs_pkg::REG_CENTER: prdata = 32'(r_center);
            default:             prdata = '0;
        endcase
    end

    // pipe advance
    logic en;
    logic r_o_vld;
    logic [DW-1:0] r_o_data;

    assign en      = !r_o_vld || i_ready;
    assign o_ready = en;

    // stage a: saturate and classify
    rcs_pkg::t_side n_a_side, r_a_side;
    logic           r_a_vld;

    always_comb begin
        n_a_side      = '0;
        n_a_side.pass = (r_effect == '0) || (r_mode > rcs_pkg::MODE_LEAN_OUT);
        n_a_side.raw  = i_sample_in;
        n_a_side.x    = rcs_pkg::sat(i_sample_in);
        n_a_side.m    = rcs_pkg::sat(r_effect);
        n_a_side.c    = rcs_pkg::sat(r_center);
        n_a_side.mode = r_mode;
        n_a_side.gt   = n_a_side.x > n_a_side.c;
        n_a_side.lt   = n_a_side.x < n_a_side.c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_side <= n_a_side;
        end
    end

    // side rescale divider operands
    logic [rcs_pkg::NUM_W-1:0] d1_num;
    logic [DW-1:0]             d1_den;

    always_comb begin
        priority if (r_a_side.gt) begin
            d1_num = rcs_pkg::NUM_W'(r_a_side.x - r_a_side.c) << FB;
            d1_den = rcs_pkg::ONE - r_a_side.c;
        end else if (r_a_side.lt) begin
            d1_num = rcs_pkg::NUM_W'(r_a_side.c - r_a_side.x) << FB;
            d1_den = r_a_side.c;
        end else begin
            d1_num = '0;
            d1_den = DW'(1);
        end
    end

    logic           d1_vld;
    logic [DW-1:0]  d1_quo;
    rcs_pkg::t_side d1_side;

    rcs_divider u_div_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_a_vld),
        .i_num   (d1_num),
        .i_den   (d1_den),
        .i_side  (r_a_side),
        .o_valid (d1_vld),
        .o_quo   (d1_quo),
        .o_side  (d1_side)
    );

    // stage c: pick curve argument, form (2 - m) * x
    rcs_pkg::t_side             n_c_side, r_c_side;
    logic [rcs_pkg::PROD_W:0]   c_prod;
    logic [rcs_pkg::NUM_W-1:0]  r_c_prod;
    logic                       r_c_vld;
    logic [DW-1:0]              su;

    always_comb begin
        n_c_side = d1_side;
        su       = rcs_pkg::sat(d1_quo);
        unique case (d1_side.mode)
            rcs_pkg::MODE_UP, rcs_pkg::MODE_UP_BLEND: n_c_side.xb = d1_side.x;
            rcs_pkg::MODE_DOWN, rcs_pkg::MODE_DOWN_BLEND:
                n_c_side.xb = rcs_pkg::ONE - d1_side.x;
            rcs_pkg::MODE_LEAN_IN: n_c_side.xb = rcs_pkg::ONE - su;
            default:               n_c_side.xb = su;
        endcase
        c_prod = ({1'b0, rcs_pkg::ONE, 1'b0} - (DW+1)'(d1_side.m)) * n_c_side.xb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_side <= n_c_side;
            r_c_prod <= c_prod[rcs_pkg::NUM_W-1:0];
        end
    end

    // curve divider
    logic [DW-1:0]  d2_den;
    logic           d2_vld;
    logic [DW-1:0]  d2_quo;
    rcs_pkg::t_side d2_side;

    assign d2_den = rcs_pkg::ONE - r_c_side.m + r_c_side.xb;

    rcs_divider u_div_curve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_c_vld),
        .i_num   (r_c_prod),
        .i_den   (d2_den),
        .i_side  (r_c_side),
        .o_valid (d2_vld),
        .o_quo   (d2_quo),
        .o_side  (d2_side)
    );

    // stage e: map the bent side value back by its span
    logic [DW-1:0]             e_g, e_scale;
    logic [rcs_pkg::PROD_W-1:0] r_e_prod;
    logic [DW-1:0]             r_e_b;
    rcs_pkg::t_side            r_e_side;
    logic                      r_e_vld;

    assign e_g     = (d2_side.mode == rcs_pkg::MODE_LEAN_IN) ? (rcs_pkg::ONE - d2_quo) : d2_quo;
    assign e_scale = d2_side.gt ? (rcs_pkg::ONE - d2_side.c) : d2_side.c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (en) begin
            r_e_vld <= d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_side <= d2_side;
            r_e_b    <= d2_quo;
            r_e_prod <= e_g * e_scale;
        end
    end

    // stage f: final combine into the output register
    logic [DW-1:0] n_o_data, sc, y;
    logic [DW:0]   bsum;

    always_comb begin
        sc = r_e_prod[FB+DW-1:FB];
        y  = rcs_pkg::ONE - r_e_side.x;
        bsum = '0;
        if (r_e_side.pass) begin
            n_o_data = r_e_side.raw;
        end else begin
            unique case (r_e_side.mode)
                rcs_pkg::MODE_UP:   n_o_data = r_e_b;
                rcs_pkg::MODE_DOWN: n_o_data = rcs_pkg::ONE - r_e_b;
                rcs_pkg::MODE_UP_BLEND: begin
                    bsum     = (DW+1)'(r_e_b) + (DW+1)'(r_e_side.x);
                    n_o_data = bsum[DW:1];
                end
                rcs_pkg::MODE_DOWN_BLEND: begin
                    bsum     = (DW+1)'(r_e_b) + (DW+1)'(y);
                    n_o_data = rcs_pkg::ONE - bsum[DW:1];
                end
                default: begin
                    priority if (r_e_side.gt) n_o_data = r_e_side.c + sc;
                    else if (r_e_side.lt)     n_o_data = r_e_side.c - sc;
                    else                      n_o_data = r_e_side.x;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_data <= n_o_data;
        end
    end

    assign o_valid      = r_o_vld;
    assign o_sample_out = r_o_data;

endmodule

// ===== sv/rcs_divider.sv =====
// ----------------------------------------------------------------------------
// rcs_divider
// Restoring divider, one quotient bit per register stage, sideband carried.
// ----------------------------------------------------------------------------
module rcs_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [rcs_pkg::NUM_W-1:0]   i_num,
    input  logic [rcs_pkg::DATA_W-1:0]  i_den,
    input  rcs_pkg::t_side              i_side,
    output logic                        o_valid,
    output logic [rcs_pkg::DATA_W-1:0]  o_quo,
    output rcs_pkg::t_side              o_side
);

    localparam int QW = rcs_pkg::DATA_W;

    logic [rcs_pkg::REM_W-1:0]  r_rem [QW-1];
    logic [rcs_pkg::DATA_W-1:0] r_den [QW];
    logic [rcs_pkg::DATA_W-1:0] r_quo [QW];
    rcs_pkg::t_side             r_side [QW];
    logic [QW-1:0]              r_vld;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int BIT = QW - 1 - k;
        logic [rcs_pkg::REM_W-1:0]  rem_in, trial, n_rem;
        logic [rcs_pkg::DATA_W-1:0] den_in, quo_in, n_quo;
        rcs_pkg::t_side             side_in;
        logic                       vld_in, fit;

        if (k == 0) begin : g_first
            assign rem_in  = rcs_pkg::REM_W'(i_num);
            assign den_in  = i_den;
            assign quo_in  = '0;
            assign side_in = i_side;
            assign vld_in  = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign den_in  = r_den[k-1];
            assign quo_in  = r_quo[k-1];
            assign side_in = r_side[k-1];
            assign vld_in  = r_vld[k-1];
        end

        always_comb begin
            trial    = rcs_pkg::REM_W'(den_in) << BIT;
            fit      = (rem_in >= trial);
            n_rem    = fit ? (rem_in - trial) : rem_in;
            n_quo    = quo_in;
            n_quo[BIT] = fit;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k]  <= den_in;
                r_quo[k]  <= n_quo;
                r_side[k] <= side_in;
            end
        end

        // the last stage only needs the quotient
        if (k < QW - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                end
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

// ===== sv/rcs_checker.sv =====
// ----------------------------------------------------------------------------
// rcs_checker
// Port-level checks of the shaper, bound to the top level.
// ----------------------------------------------------------------------------
`include "rational_curve_shaper_macros.svh"

module rcs_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [rcs_pkg::DATA_W-1:0]  o_sample_out
);

    // a waiting result beat holds
    `RCS_ASSERT_NEXT(a_out_hold, i_rst_n && o_valid && !i_ready, o_valid && $stable(o_sample_out))

    // input side backs up only when a result is stuck
    `RCS_ASSERT_SAME(a_ready_link, 1'b1, o_ready == (!o_valid || i_ready))

    // no result right after reset
    `RCS_ASSERT_NEXT(a_reset_empty, !i_rst_n, !o_valid)

endmodule

bind rational_curve_shaper rcs_checker u_rcs_checker (.*);
